### rtl/gaussian_sinusoid_field_voxel_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel field core
// Shared concurrent-assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_SINUSOID_FIELD_VOXEL_CORE_DEFINES_SVH
`define GAUSSIAN_SINUSOID_FIELD_VOXEL_CORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define GSFV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsfv: same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define GSFV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsfv: next-cycle check failed");

// Check of what reset leaves behind in the cycle after it is seen.
`define GSFV_ASSERT_RESET(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("gsfv: reset check failed");

`endif

### rtl/gsfv_pkg.sv
// ----------------------------------------------------------------------------
// gsfv_pkg
// Types, widths, constants and tables shared by the voxel field core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsfv_pkg;

  localparam int INDEX_BITS = 11;
  localparam int CENTER_W   = 20;
  localparam int RECIP_W    = 17;
  localparam int AMP_W      = 16;
  localparam int GSCALE_W   = 16;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Difference center - index*256 and the normalized coordinate magnitude.
  localparam int D_W    = ((INDEX_BITS + 8 > CENTER_W) ? INDEX_BITS + 8 : CENTER_W) + 1;
  localparam int DMAG_W = D_W - 1;
  localparam int CMAG_W = DMAG_W + RECIP_W - 8;

  typedef logic signed [INDEX_BITS-1:0] index_t;
  typedef logic signed [CENTER_W-1:0]   center_t;
  typedef logic [RECIP_W-1:0]           recip_t;
  typedef logic [AMP_W-1:0]             amp_t;
  typedef logic [GSCALE_W-1:0]          gscale_t;
  typedef logic signed [OUT_W-1:0]      voxel_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;
  typedef logic [CMAG_W-1:0]            cmag_t;
  typedef logic signed [13:0]           term_t;
  typedef logic [16:0]                  gauss_t;

  typedef struct packed {
    logic  neg;
    cmag_t mag;
  } coord_t;

  typedef struct packed {
    logic [19:0] k;
    logic [12:0] mag256;
    logic        cosine;
  } wave_cfg_t;

  localparam cfg_idx_t CFG_AMPLITUDE    = 3'd0;
  localparam cfg_idx_t CFG_GAUSS_SCALE  = 3'd1;
  localparam cfg_idx_t CFG_CENTER_X     = 3'd2;
  localparam cfg_idx_t CFG_CENTER_Y     = 3'd3;
  localparam cfg_idx_t CFG_CENTER_Z     = 3'd4;
  localparam cfg_idx_t CFG_SPAN_RECIP_X = 3'd5;
  localparam cfg_idx_t CFG_SPAN_RECIP_Y = 3'd6;
  localparam cfg_idx_t CFG_SPAN_RECIP_Z = 3'd7;

  localparam amp_t    AMPLITUDE_RST   = 16'd65280;
  localparam gscale_t GAUSS_SCALE_RST = 16'd512;
  localparam center_t CENTER_RST      = 20'sd0;
  localparam recip_t  SPAN_RECIP_RST  = 17'd3277;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam wave_cfg_t WCFG_X = '{k: 20'd625823, mag256: 13'd2560, cosine: 1'b0};
  localparam wave_cfg_t WCFG_Y = '{k: 20'd312911, mag256: 13'd4608, cosine: 1'b0};
  localparam wave_cfg_t WCFG_Z = '{k: 20'd417215, mag256: 13'd1280, cosine: 1'b1};

  // 2^-(2^-(k+1)) in Q.16 for the fractional exponent bits, top bit first.
  localparam logic [15:0] POW2_NEG_FRAC [16] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830, 16'd65181, 16'd65358,
    16'd65447, 16'd65492, 16'd65514, 16'd65525, 16'd65530, 16'd65533, 16'd65535, 16'd65535
  };

  // Odd Taylor polynomial for sin in Q.30, Horner form.
  localparam logic signed [31:0] HORNER_P0 = 32'sd172273;
  localparam logic signed [31:0] HORNER_C [4] = '{
    -32'sd5026995, 32'sd85569308, -32'sd693598669, 32'sd1686629713
  };

  // Pipeline depths of the units, in register stages.
  localparam int LAT_COORD  = 3;
  localparam int LAT_GAUSS  = 26;
  localparam int LAT_WAVE   = 16;
  localparam int WAVE_ALIGN = LAT_GAUSS - LAT_WAVE;
  localparam int PIPE_DEPTH = LAT_COORD + LAT_GAUSS + 1;

  localparam int SUM_W = OUT_W + 2;
  localparam logic signed [SUM_W-1:0] OUT_MAX = 26'sd8388607;
  localparam logic signed [SUM_W-1:0] OUT_MIN = -26'sd8388608;

  // Reachable output range: full gaussian plus all three wave magnitudes.
  localparam voxel_t VOXEL_HI = 24'sd73983;
  localparam voxel_t VOXEL_LO = -24'sd8448;

endpackage

### rtl/gsfv_chan_if.sv
// ----------------------------------------------------------------------------
// gsfv channel interfaces
// Valid/ready channels for voxel index beats and field value beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gsfv_in_if;
  import gsfv_pkg::*;

  logic   valid;
  logic   ready;
  index_t index_x;
  index_t index_y;
  index_t index_z;

  modport source (output valid, output index_x, output index_y, output index_z, input ready);
  modport sink (input valid, input index_x, input index_y, input index_z, output ready);
endinterface

interface gsfv_out_if;
  import gsfv_pkg::*;

  logic   valid;
  logic   ready;
  voxel_t voxel_value;

  modport source (output valid, output voxel_value, input ready);
  modport sink (input valid, input voxel_value, output ready);
endinterface

### rtl/gsfv_coord.sv
// ----------------------------------------------------------------------------
// gsfv_coord
// Three-stage normalized coordinate: (center - index) times reciprocal span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfv_coord (
  input  logic             clk,
  input  logic             ce,
  input  gsfv_pkg::index_t  index_i,
  input  gsfv_pkg::center_t center_i,
  input  gsfv_pkg::recip_t  recip_i,
  output gsfv_pkg::coord_t  coord_o
);
  import gsfv_pkg::*;

  localparam int PW = DMAG_W + RECIP_W;

  logic signed [D_W-1:0] d;
  logic [DMAG_W-1:0]     dmag;
  logic [DMAG_W-1:0]     dmag_r;
  logic                  neg1_r;
  logic [PW-1:0]         prod_r;
  logic                  neg2_r;
  coord_t                coord_r;

  always_comb begin
    d    = D_W'(center_i) - (D_W'(index_i) <<< 8);
    dmag = d[D_W-1] ? DMAG_W'(-d) : DMAG_W'(d);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dmag_r       <= dmag;
      neg1_r       <= d[D_W-1];
      prod_r       <= PW'(dmag_r) * PW'(recip_i);
      neg2_r       <= neg1_r;
      // Magnitude rounded half up, sign kept apart.
      coord_r.mag  <= CMAG_W'((prod_r + PW'(128)) >> 8);
      coord_r.neg  <= neg2_r;
    end
  end

  assign coord_o = coord_r;

endmodule

### rtl/gsfv_gauss.sv
// ----------------------------------------------------------------------------
// gsfv_gauss
// Pipelined amplitude * exp(-r^2 * scale) with a base-2 bit-serial exponent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfv_gauss (
  input  logic              clk,
  input  logic              ce,
  input  gsfv_pkg::coord_t  cx_i,
  input  gsfv_pkg::coord_t  cy_i,
  input  gsfv_pkg::coord_t  cz_i,
  input  gsfv_pkg::amp_t    amplitude_i,
  input  gsfv_pkg::gscale_t gscale_i,
  output gsfv_pkg::gauss_t  gauss_o
);
  import gsfv_pkg::*;

  localparam logic [6:0]  TI_FLUSH  = 7'd127;
  localparam logic [24:0] CLAMP_MAG = 25'h100_0000;

  coord_t      c [3];
  logic [24:0] cl [3];
  logic [49:0] sqp_r [3];
  logic [32:0] sq_r [3];
  logic [33:0] sum_r;
  logic [49:0] ep_r;
  logic [41:0] e_full;
  logic [21:0] e_r;
  logic        big_r;
  logic [38:0] tp_r;
  logic        big6_r;
  logic [22:0] t;
  logic [16:0] r_r [17];
  logic [15:0] tf_r [16];
  logic [6:0]  ti_r [17];
  logic [16:0] expv_r;
  logic [32:0] ap_r;
  gauss_t      gauss_r;

  always_comb begin
    c[0] = cx_i;
    c[1] = cy_i;
    c[2] = cz_i;
    for (int a = 0; a < 3; a++) begin
      cl[a] = (c[a].mag > CMAG_W'(CLAMP_MAG)) ? CLAMP_MAG : 25'(c[a].mag);
    end
    e_full = 42'((ep_r + 50'd128) >> 8);
    t      = 23'((tp_r + 39'd32768) >> 16);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int a = 0; a < 3; a++) begin
        sqp_r[a] <= 50'(cl[a]) * 50'(cl[a]);
        sq_r[a]  <= 33'((sqp_r[a] + 50'd32768) >> 16);
      end
      sum_r  <= 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
      ep_r   <= 50'(sum_r) * 50'(gscale_i);
      e_r    <= e_full[21:0];
      big_r  <= |e_full[41:22];
      tp_r   <= 39'(e_r) * 39'(LOG2E_Q16);
      big6_r <= big_r;
      // An exponent of 64 or more flushes the result through a huge shift.
      ti_r[0] <= big6_r ? TI_FLUSH : t[22:16];
      tf_r[0] <= t[15:0];
      r_r[0]  <= 17'd65536;
      for (int k = 0; k < 16; k++) begin
        r_r[k+1]  <= tf_r[k][15-k]
                     ? 17'((34'(r_r[k]) * 34'(POW2_NEG_FRAC[k]) + 34'd32768) >> 16)
                     : r_r[k];
        ti_r[k+1] <= ti_r[k];
        if (k < 15) begin
          tf_r[k+1] <= tf_r[k];
        end
      end
      expv_r  <= (ti_r[16] >= 7'd32) ? 17'd0 : (r_r[16] >> ti_r[16]);
      ap_r    <= 33'(amplitude_i) * 33'(expv_r);
      gauss_r <= 17'((ap_r + 33'd32768) >> 16);
    end
  end

  assign gauss_o = gauss_r;

endmodule

### rtl/gsfv_wave.sv
// ----------------------------------------------------------------------------
// gsfv_wave
// Pipelined magnitude * sin(2*pi*phase) term (cos when cosine is set) from a normalized coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfv_wave (
  input  logic                clk,
  input  logic                ce,
  input  gsfv_pkg::coord_t    c_i,
  input  gsfv_pkg::wave_cfg_t cfg_i,
  output gsfv_pkg::term_t     term_o
);
  import gsfv_pkg::*;

  localparam logic [61:0] HALF_Q30 = 62'd536870912;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

  logic signed [CMAG_W:0] cs;
  logic [31:0]            c32;
  logic [31:0]            pp_r;
  logic [31:0]            ph;
  logic [30:0]            s_r;
  logic [1:0]             q_r;
  logic [61:0]            ss_r;
  logic [30:0]            s3_r;
  logic [1:0]             q3_r;
  logic [30:0]            s2_r;
  logic [30:0]            s4_r;
  logic [1:0]             q4_r;

  logic signed [31:0]     in_p [4];
  logic [30:0]            in_s2 [4];
  logic [30:0]            in_s [4];
  logic [1:0]             in_q [4];
  logic [30:0]            pmag [4];
  logic [31:0]            hmr [4];

  logic [61:0]            hm_r [4];
  logic                   hneg_r [4];
  logic [30:0]            ms2_r [4];
  logic [30:0]            ms_r [4];
  logic [1:0]             mq_r [4];
  logic signed [31:0]     p_r [4];
  logic [30:0]            as2_r [4];
  logic [30:0]            as_r [4];
  logic [1:0]             aq_r [4];

  logic [30:0]            fmag;
  logic [61:0]            fm_r;
  logic                   fneg_r;
  logic [1:0]             fq_r;
  logic [31:0]            fv;
  logic [30:0]            sv_r;
  logic [1:0]             sq_r;
  logic [43:0]            tm_r;
  logic                   tneg_r;
  logic [13:0]            tmag;
  term_t                  term_r;

  always_comb begin
    cs  = c_i.neg ? -$signed({1'b0, c_i.mag}) : $signed({1'b0, c_i.mag});
    c32 = 32'(cs);
    ph  = pp_r + (cfg_i.cosine ? QUARTER_TURN : 32'd0);
    for (int k = 0; k < 4; k++) begin
      if (k == 0) begin
        in_p[k]  = HORNER_P0;
        in_s2[k] = s2_r;
        in_s[k]  = s4_r;
        in_q[k]  = q4_r;
      end else begin
        in_p[k]  = p_r[k-1];
        in_s2[k] = as2_r[k-1];
        in_s[k]  = as_r[k-1];
        in_q[k]  = aq_r[k-1];
      end
      pmag[k] = in_p[k][31] ? 31'(-in_p[k]) : 31'(in_p[k]);
      hmr[k]  = 32'((hm_r[k] + HALF_Q30) >> 30);
    end
    fmag = p_r[3][31] ? 31'(-p_r[3]) : 31'(p_r[3]);
    fv   = 32'((fm_r + HALF_Q30) >> 30);
    tmag = 14'((tm_r + 44'(HALF_Q30)) >> 30);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // Phase in Q.32 turns is the low word of c * K.
      pp_r <= c32 * 32'(cfg_i.k);
      q_r  <= ph[31:30];
      s_r  <= ph[30] ? ONE_Q30 - 31'(ph[29:0]) : 31'(ph[29:0]);
      ss_r <= 62'(s_r) * 62'(s_r);
      s3_r <= s_r;
      q3_r <= q_r;
      s2_r <= 31'((ss_r + HALF_Q30) >> 30);
      s4_r <= s3_r;
      q4_r <= q3_r;
      for (int k = 0; k < 4; k++) begin
        hm_r[k]   <= 62'(pmag[k]) * 62'(in_s2[k]);
        hneg_r[k] <= in_p[k][31];
        ms2_r[k]  <= in_s2[k];
        ms_r[k]   <= in_s[k];
        mq_r[k]   <= in_q[k];
        p_r[k]    <= HORNER_C[k] + (hneg_r[k] ? -$signed(hmr[k]) : $signed(hmr[k]));
        as2_r[k]  <= ms2_r[k];
        as_r[k]   <= ms_r[k];
        aq_r[k]   <= mq_r[k];
      end
      fm_r   <= 62'(fmag) * 62'(as_r[3]);
      fneg_r <= p_r[3][31];
      fq_r   <= aq_r[3];
      // The polynomial is clamped to [0, 1] before the quadrant sign.
      if (fneg_r) begin
        sv_r <= 31'd0;
      end else if (fv > 32'(ONE_Q30)) begin
        sv_r <= ONE_Q30;
      end else begin
        sv_r <= 31'(fv);
      end
      sq_r   <= fq_r;
      tm_r   <= 44'(cfg_i.mag256) * 44'(sv_r);
      tneg_r <= sq_r[1];
      term_r <= tneg_r ? -$signed(tmag) : $signed(tmag);
    end
  end

  assign term_o = term_r;

endmodule

### rtl/gaussian_sinusoid_field_voxel_core.sv
// ----------------------------------------------------------------------------
// gaussian_sinusoid_field_voxel_core
// Samples a gaussian blob plus three axis sinusoids at one voxel per beat.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload                               Handshake
//   in_chan    in         index_x, index_y, index_z (signed)    valid / ready
//   out_chan   out        voxel_value (signed Q15.8, saturated) valid / ready
//   cfg_*      in         cfg_index, cfg_data                   cfg_we
//
// One beat is accepted per clock cycle when the output side keeps up.
// The pipeline depth from a taken input beat to the output register is set by the
// exponential, which applies one multiply stage per fractional exponent bit
// (sixteen stages) after the coordinate and square units.
// Synchronous active-low reset clears the valid bits, including the output valid,
// and restores the configuration registers; data registers are not reset.
// The pipeline only freezes when the output register holds an untaken beat
// and the last stage holds another one, so no beat is lost or repeated.
//
`timescale 1ns / 1ps

module gaussian_sinusoid_field_voxel_core (
  input  logic                clk,
  input  logic                rst_n,
  gsfv_in_if.sink             in_chan,
  gsfv_out_if.source          out_chan,
  input  logic                cfg_we,
  input  gsfv_pkg::cfg_idx_t  cfg_index,
  input  gsfv_pkg::cfg_data_t cfg_data
);
  import gsfv_pkg::*;

  // Configuration registers; the user must write them only while the core is idle, the block does not enforce it.
  amp_t    amplitude_r;
  gscale_t gauss_scale_r;
  center_t center_x_r;
  center_t center_y_r;
  center_t center_z_r;
  recip_t  span_recip_x_r;
  recip_t  span_recip_y_r;
  recip_t  span_recip_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r    <= AMPLITUDE_RST;
      gauss_scale_r  <= GAUSS_SCALE_RST;
      center_x_r     <= CENTER_RST;
      center_y_r     <= CENTER_RST;
      center_z_r     <= CENTER_RST;
      span_recip_x_r <= SPAN_RECIP_RST;
      span_recip_y_r <= SPAN_RECIP_RST;
      span_recip_z_r <= SPAN_RECIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AMPLITUDE:    amplitude_r    <= cfg_data[AMP_W-1:0];
        CFG_GAUSS_SCALE:  gauss_scale_r  <= cfg_data[GSCALE_W-1:0];
        CFG_CENTER_X:     center_x_r     <= center_t'(cfg_data[CENTER_W-1:0]);
        CFG_CENTER_Y:     center_y_r     <= center_t'(cfg_data[CENTER_W-1:0]);
        CFG_CENTER_Z:     center_z_r     <= center_t'(cfg_data[CENTER_W-1:0]);
        CFG_SPAN_RECIP_X: span_recip_x_r <= cfg_data[RECIP_W-1:0];
        CFG_SPAN_RECIP_Y: span_recip_y_r <= cfg_data[RECIP_W-1:0];
        CFG_SPAN_RECIP_Z: span_recip_z_r <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: every stage moves together unless the output register
  // is still waiting and the last stage has a beat ready to drop into it.
  logic                   ce;
  logic [PIPE_DEPTH-1:0]  v_r;
  logic                   out_valid_r;
  voxel_t                 out_r;

  assign ce            = !(out_valid_r && !out_chan.ready && v_r[PIPE_DEPTH-1]);
  assign in_chan.ready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[PIPE_DEPTH-2:0], in_chan.valid};
    end
  end

  // Per-axis normalized coordinates.
  coord_t cx;
  coord_t cy;
  coord_t cz;

  gsfv_coord u_coord_x (
    .clk(clk), .ce(ce), .index_i(in_chan.index_x), .center_i(center_x_r),
    .recip_i(span_recip_x_r), .coord_o(cx)
  );
  gsfv_coord u_coord_y (
    .clk(clk), .ce(ce), .index_i(in_chan.index_y), .center_i(center_y_r),
    .recip_i(span_recip_y_r), .coord_o(cy)
  );
  gsfv_coord u_coord_z (
    .clk(clk), .ce(ce), .index_i(in_chan.index_z), .center_i(center_z_r),
    .recip_i(span_recip_z_r), .coord_o(cz)
  );

  // Gaussian term, the long path of the core.
  gauss_t gauss;

  gsfv_gauss u_gauss (
    .clk(clk), .ce(ce), .cx_i(cx), .cy_i(cy), .cz_i(cz),
    .amplitude_i(amplitude_r), .gscale_i(gauss_scale_r), .gauss_o(gauss)
  );

  // Sinusoid terms, delayed afterwards to line up with the gaussian.
  term_t wx;
  term_t wy;
  term_t wz;

  gsfv_wave u_wave_x (.clk(clk), .ce(ce), .c_i(cx), .cfg_i(WCFG_X), .term_o(wx));
  gsfv_wave u_wave_y (.clk(clk), .ce(ce), .c_i(cy), .cfg_i(WCFG_Y), .term_o(wy));
  gsfv_wave u_wave_z (.clk(clk), .ce(ce), .c_i(cz), .cfg_i(WCFG_Z), .term_o(wz));

  term_t wdx_r [WAVE_ALIGN];
  term_t wdy_r [WAVE_ALIGN];
  term_t wdz_r [WAVE_ALIGN];

  always_ff @(posedge clk) begin
    if (ce) begin
      wdx_r[0] <= wx;
      wdy_r[0] <= wy;
      wdz_r[0] <= wz;
      for (int i = 1; i < WAVE_ALIGN; i++) begin
        wdx_r[i] <= wdx_r[i-1];
        wdy_r[i] <= wdy_r[i-1];
        wdz_r[i] <= wdz_r[i-1];
      end
    end
  end

  // Final sum and saturation to signed Q15.8.
  logic signed [SUM_W-1:0] total;
  voxel_t                  sum_r;

  always_comb begin
    total = $signed(SUM_W'(gauss)) + SUM_W'(wdx_r[WAVE_ALIGN-1])
          + SUM_W'(wdy_r[WAVE_ALIGN-1]) + SUM_W'(wdz_r[WAVE_ALIGN-1]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (total > OUT_MAX) begin
        sum_r <= OUT_MAX[OUT_W-1:0];
      end else if (total < OUT_MIN) begin
        sum_r <= OUT_MIN[OUT_W-1:0];
      end else begin
        sum_r <= total[OUT_W-1:0];
      end
    end
  end

  // Output register: holds a beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v_r[PIPE_DEPTH-1] && ce) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_r[PIPE_DEPTH-1] && ce) begin
      out_r <= sum_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.voxel_value = out_r;

endmodule

### rtl/gsfv_checker.sv
// ----------------------------------------------------------------------------
// gsfv_checker
// Port-level checks of the voxel field core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gaussian_sinusoid_field_voxel_core_defines.svh"

module gsfv_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input gsfv_pkg::voxel_t out_value
);
  import gsfv_pkg::*;

  // Reset empties the output register.
  `GSFV_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_valid)

  // An untaken beat stays put.
  `GSFV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value))

  // Input back-pressure only comes from a blocked output.
  `GSFV_ASSERT_IMPLY(a_ready_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

  // Gaussian plus wave magnitudes bound every value the core can produce.
  `GSFV_ASSERT_IMPLY(a_value_range, clk, rst_n, out_valid, (out_value <= VOXEL_HI) && (out_value >= VOXEL_LO))

endmodule

bind gaussian_sinusoid_field_voxel_core gsfv_checker u_gsfv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.voxel_value)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel field core. Index beats are driven with
// random gaps while the result side stalls at random. A bit-exact fixed-point
// model predicts every field value, and each result beat is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gsfv_pkg::*;

  // Clock and reset. The clock period is 4 ns, and reset is held low at the start of the run.
  logic clk;
  logic rst_n;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The channels and the register write port.
  gsfv_in_if  in_chan ();
  gsfv_out_if out_chan ();

  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  gaussian_sinusoid_field_voxel_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The bench keeps its own copy of the register file. It changes only while
  // the core is drained, so each prediction can be made when its beat is taken.
  amp_t    amp_reg;
  gscale_t gscale_reg;
  center_t center_reg [3];
  recip_t  recip_reg [3];

  // The field values that are still expected, oldest first.
  voxel_t pending_values [$];

  int mismatch_count;
  int stray_count;
  int sent_count;
  int checked_count;
  int cfg_write_count;

  // These controls are shared with the result-side process.
  bit no_idle;
  int hold_left;

  // The table of 2^-(2^-(k+1)) in Q.16. Entry k is applied when fractional bit k of the
  // exponent, counted from the top, is set.
  localparam longint unsigned FRAC_TABLE [16] = '{
    46341, 55109, 60097, 62757, 64132, 64830, 65181, 65358,
    65447, 65492, 65514, 65525, 65530, 65533, 65535, 65535
  };

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Signed Q.30 product. The magnitude is rounded half up.
  function automatic longint q30_mul(longint a, longint b);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    m  = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Normalized coordinate in Q.16: (center - index) scaled by the reciprocal span.
  function automatic longint axis_coord(center_t ctr, index_t idx, recip_t rc);
    longint d;
    longint unsigned dm, m;
    d  = longint'(ctr) - longint'(idx) * 256;
    dm = (d < 0) ? longint'(-d) : d;
    m  = (dm * longint'(rc) + 128) >> 8;
    return (d < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Square of one coordinate in Q.16. The magnitude is clamped at 256.0.
  function automatic longint unsigned coord_square(longint c);
    longint unsigned m;
    m = (c < 0) ? longint'(-c) : c;
    if (m > (64'd1 << 24)) m = 64'd1 << 24;
    return (m * m + 32768) >> 16;
  endfunction

  // Sine of a phase given in Q.32 turns, in Q.30. The phase is folded into the
  // first quadrant, and an odd polynomial is evaluated there.
  function automatic longint phase_sine(logic [31:0] ph);
    longint s, s2, p;
    s = longint'({2'b00, ph[29:0]});
    if (ph[30]) s = (64'sd1 <<< 30) - s;
    s2 = q30_mul(s, s);
    p  = 172273;
    p  = -5026995 + q30_mul(p, s2);
    p  = 85569308 + q30_mul(p, s2);
    p  = -693598669 + q30_mul(p, s2);
    p  = 1686629713 + q30_mul(p, s2);
    p  = q30_mul(p, s);
    if (p > (64'sd1 <<< 30)) p = 64'sd1 <<< 30;
    if (p < 0) p = 0;
    return ph[31] ? -p : p;
  endfunction

  // One sinusoid term in Q.8. The phase is the low 32 bits of c times k.
  function automatic longint sinusoid_term(longint c, longint k, longint mag, bit cosine);
    logic [63:0] prod;
    logic [31:0] ph;
    prod = c * k;
    ph   = prod[31:0];
    if (cosine) ph = ph + 32'h4000_0000;
    return q30_mul(mag * 256, phase_sine(ph));
  endfunction

  // Gaussian term in Q.8. The exponential is built as 2^-(e*log2(e)).
  function automatic longint gaussian_term(longint cx, longint cy, longint cz);
    longint unsigned sum, e, t, r, expv;
    longint unsigned ti;
    logic [15:0] tf;
    sum = coord_square(cx) + coord_square(cy) + coord_square(cz);
    e   = (sum * longint'(gscale_reg) + 128) >> 8;
    if (e >= (64'd1 << 22)) return 0;
    t  = (e * 94548 + 32768) >> 16;
    ti = t >> 16;
    tf = t[15:0];
    r  = 65536;
    for (int k = 0; k < 16; k++) begin
      if (tf[15-k]) r = (r * FRAC_TABLE[k] + 32768) >> 16;
    end
    expv = (ti >= 32) ? 0 : (r >> ti);
    return longint'((longint'(amp_reg) * expv + 32768) >> 16);
  endfunction

  // The full field value at one voxel, saturated to Q15.8.
  function automatic voxel_t field_value(index_t ix, index_t iy, index_t iz);
    longint cx, cy, cz, total;
    logic [63:0] bits;
    cx = axis_coord(center_reg[0], ix, recip_reg[0]);
    cy = axis_coord(center_reg[1], iy, recip_reg[1]);
    cz = axis_coord(center_reg[2], iz, recip_reg[2]);
    total = gaussian_term(cx, cy, cz)
          + sinusoid_term(cx, 625823, 10, 1'b0)
          + sinusoid_term(cy, 312911, 18, 1'b0)
          + sinusoid_term(cz, 417215, 5, 1'b1);
    if (total > 8388607) total = 8388607;
    if (total < -8388608) total = -8388608;
    bits = total;
    return voxel_t'(bits[23:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Writes one register and updates the bench's copy. The write enable is
  // raised at a falling edge and lowered again before the task returns.
  task automatic cfg_write(cfg_idx_t idx, cfg_data_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_AMPLITUDE:    amp_reg       = value[15:0];
      CFG_GAUSS_SCALE:  gscale_reg    = value[15:0];
      CFG_CENTER_X:     center_reg[0] = value[19:0];
      CFG_CENTER_Y:     center_reg[1] = value[19:0];
      CFG_CENTER_Z:     center_reg[2] = value[19:0];
      CFG_SPAN_RECIP_X: recip_reg[0]  = value[16:0];
      CFG_SPAN_RECIP_Y: recip_reg[1]  = value[16:0];
      CFG_SPAN_RECIP_Z: recip_reg[2]  = value[16:0];
      default: ;
    endcase
    cfg_write_count++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes all eight registers.
  task automatic cfg_write_all(amp_t amp, gscale_t gs, center_t c [3], recip_t rc [3]);
    cfg_write(CFG_AMPLITUDE, cfg_data_t'(amp));
    cfg_write(CFG_GAUSS_SCALE, cfg_data_t'(gs));
    cfg_write(CFG_CENTER_X, cfg_data_t'(c[0]));
    cfg_write(CFG_CENTER_Y, cfg_data_t'(c[1]));
    cfg_write(CFG_CENTER_Z, cfg_data_t'(c[2]));
    cfg_write(CFG_SPAN_RECIP_X, cfg_data_t'(rc[0]));
    cfg_write(CFG_SPAN_RECIP_Y, cfg_data_t'(rc[1]));
    cfg_write(CFG_SPAN_RECIP_Z, cfg_data_t'(rc[2]));
  endtask

  // Offers one index beat and holds it until the core takes it. Any idle
  // cycles come first. Valid stays high into the next call, so back-to-back
  // beats never drop it.
  task automatic send_voxel(index_t ix, index_t iy, index_t iz);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 31) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.index_x <= ix;
    in_chan.index_y <= iy;
    in_chan.index_z <= iz;
    do @(posedge clk); while (!in_chan.ready);
    pending_values.push_back(field_value(ix, iy, iz));
    sent_count++;
  endtask

  // Stops offering beats and waits until every expected value has come back,
  // then a little longer so that the pipeline is empty.
  task automatic drain_results();
    int guard;
    @(negedge clk);
    in_chan.valid <= 1'b0;
    guard = 0;
    while (pending_values.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_values.size() != 0) begin
      $display("timeout while draining, %0d values outstanding", pending_values.size());
      $display("gaussian_sinusoid_field_voxel_core verification failed");
      $finish;
    end else begin
      repeat (PIPE_DEPTH + 10) @(posedge clk);
    end
  endtask

  // Random index, with every bit free.
  function automatic index_t any_index();
    return index_t'($urandom);
  endfunction

  // Index within a few voxels of the integer part of a center, so that the
  // gaussian term is not always zero.
  function automatic index_t near_index(center_t ctr, int spread);
    int v;
    v = (int'(ctr) >>> 8) + $urandom_range(0, 2 * spread) - spread;
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return index_t'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, a counted hold-off, and the checker
  // ---------------------------------------------------------------------------

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= no_idle || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    voxel_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_values.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= 10)
          $display("unexpected voxel beat %0d with nothing pending", out_chan.voxel_value);
      end else begin
        want = pending_values.pop_front();
        checked_count++;
        if (out_chan.voxel_value !== want) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= 10)
            $display("voxel_value mismatch at result %0d: expected %0d, got %0d",
                     checked_count, want, out_chan.voxel_value);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings, index extremes, and a voxel on the center.
  task automatic test_directed_defaults();
    index_t edges [5] = '{-11'sd1024, 11'sd1023, 11'sd0, -11'sd1, 11'sd1};
    send_voxel(0, 0, 0);
    for (int i = 0; i < 5; i++) send_voxel(edges[i], edges[(i + 1) % 5], edges[(i + 3) % 5]);
    send_voxel(-11'sd1024, -11'sd1024, -11'sd1024);
    send_voxel(11'sd1023, 11'sd1023, 11'sd1023);
    send_voxel(3, -2, 5);
    drain_results();
  endtask

  // Register extremes: zero gauss scale makes the exponential exactly one,
  // the largest scale pushes it to zero, and the spans reach zero, one and
  // the largest value that fits in the register.
  task automatic test_config_extremes();
    center_t c [3];
    recip_t  rc [3];
    c  = '{center_t'(20'sh7FFFF), center_t'(20'sh80000), center_t'(0)};
    rc = '{recip_t'(0), recip_t'(65536), recip_t'(17'h1FFFF)};
    cfg_write_all(16'hFFFF, 16'd0, c, rc);
    send_voxel(0, 0, 0);
    send_voxel(11'sd1023, -11'sd1024, 11'sd1023);
    send_voxel(-11'sd1024, 11'sd1023, -11'sd1024);
    send_voxel(11'sd1023, 11'sd1023, 0);
    drain_results();

    c  = '{center_t'(20'sh80000), center_t'(20'sh7FFFF), center_t'(128)};
    rc = '{recip_t'(17'h1FFFF), recip_t'(1), recip_t'(65536)};
    cfg_write_all(16'd0, 16'hFFFF, c, rc);
    send_voxel(0, 0, 0);
    send_voxel(-11'sd1024, 11'sd1023, 11'sd1);
    send_voxel(11'sd1023, -11'sd1024, -11'sd1);
    drain_results();

    // Full amplitude, the smallest nonzero scale and a centered field give a large
    // gaussian peak.
    c  = '{center_t'(0), center_t'(0), center_t'(0)};
    rc = '{recip_t'(3277), recip_t'(3277), recip_t'(3277)};
    cfg_write_all(16'hFFFF, 16'd1, c, rc);
    send_voxel(0, 0, 0);
    send_voxel(1, 1, 1);
    send_voxel(-20, 20, 10);
    drain_results();
  endtask

  // The result side holds off while beats keep coming, so the core fills up
  // and stops taking them. Then the sender waits for every result.
  task automatic test_output_holdoff();
    @(negedge clk);
    hold_left = 300;
    for (int i = 0; i < 60; i++)
      send_voxel(near_index(center_reg[0], 8), near_index(center_reg[1], 8),
                 near_index(center_reg[2], 8));
    drain_results();
  endtask

  // Random register sets, each followed by a batch of random voxels. Most
  // voxels lie near the center; the rest use the whole index range.
  task automatic test_random_phases(int phases, int per_phase);
    center_t c [3];
    recip_t  rc [3];
    amp_t    amp;
    gscale_t gs;
    for (int p = 0; p < phases; p++) begin
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(0, 3) == 0) begin
          c[a]  = center_t'($urandom);
          rc[a] = recip_t'($urandom);
        end else begin
          c[a]  = center_t'($urandom_range(0, 2 * 60 * 256) - 60 * 256);
          rc[a] = recip_t'($urandom_range(500, 20000));
        end
      end
      amp = ($urandom_range(0, 3) == 0) ? amp_t'($urandom) : amp_t'($urandom_range(0, 65280));
      gs  = ($urandom_range(0, 3) == 0) ? gscale_t'($urandom) : gscale_t'($urandom_range(0, 2048));
      cfg_write_all(amp, gs, c, rc);
      // One phase runs with no idle cycles on either side.
      no_idle = (p == 2);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_voxel(any_index(), any_index(), any_index());
        else
          send_voxel(near_index(c[0], 30), near_index(c[1], 30), near_index(c[2], 30));
      end
      drain_results();
      no_idle = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_AMPLITUDE;
    cfg_data        = '0;
    in_chan.valid   = 1'b0;
    in_chan.index_x = '0;
    in_chan.index_y = '0;
    in_chan.index_z = '0;
    no_idle         = 1'b0;
    hold_left       = 0;
    mismatch_count  = 0;
    stray_count     = 0;
    sent_count      = 0;
    checked_count   = 0;
    cfg_write_count = 0;

    // After reset the registers hold their reset values.
    amp_reg    = AMPLITUDE_RST;
    gscale_reg = GAUSS_SCALE_RST;
    for (int a = 0; a < 3; a++) begin
      center_reg[a] = CENTER_RST;
      recip_reg[a]  = SPAN_RECIP_RST;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_config_extremes();
    test_output_holdoff();
    test_random_phases(10, 105);

    $display("covered %0d voxel beats, %0d register writes, reset and extreme settings,",
             sent_count, cfg_write_count);
    $display("random stalls on both sides and a long output hold-off with input backpressure");
    if (mismatch_count == 0 && stray_count == 0 && pending_values.size() == 0) begin
      $display("gaussian_sinusoid_field_voxel_core verification clean");
    end else begin
      $display("%0d mismatches, %0d unexpected beats", mismatch_count, stray_count);
      $display("gaussian_sinusoid_field_voxel_core verification failed");
    end
    $finish;
  end

  // Watchdog with a generous margin over the slowest correct run.
  initial begin
    #2000000;
    $display("watchdog expired with %0d values outstanding", pending_values.size());
    $display("gaussian_sinusoid_field_voxel_core verification failed");
    $finish;
  end

endmodule
